// File: rtl/int_to_padded_decimal_ascii_top_assert.svh
// Assertion macros used by the decimal text converter checker.
`ifndef INT_TO_PADDED_DECIMAL_ASCII_TOP_ASSERT_SVH
`define INT_TO_PADDED_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ITPD_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("itpd checker: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ITPD_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("itpd checker: assertion failed");

`endif

// File: rtl/itpd_pkg.sv
// Shared types, constants and helper functions of the decimal text converter.
`default_nettype none

package itpd_pkg;

  // ASCII characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WIDTH = 2'd1;
  localparam logic [1:0] ST_FIT   = 2'd2;

  // Register index, word address bit 2
  localparam logic REG_BUFFER_SIZE = 1'b0;
  localparam logic REG_PAD_WIDTH   = 1'b1;

  // Largest usable destination capacity
  localparam logic [6:0] MAX_BUF = 7'd64;

  // Reciprocal of ten scaled by 2^16, exact for dividends below 16384
  localparam logic [12:0] RECIP_TEN = 13'd6554;

  // Command to the digit extraction unit
  typedef struct packed {
    logic start;
    logic load;
  } div_cmd_t;

  // Status from the digit extraction unit
  typedef struct packed {
    logic       done;
    logic       zero;
    logic [3:0] digit;
  } div_status_t;

  // Number of decimal digits in the magnitude 2^(bits-1)
  function automatic int num_digits(input int bits);
    logic [71:0] pw;
    logic [71:0] mag;
    int          n;
    pw  = 72'd1;
    mag = 72'd1 << (bits - 1);
    n   = 0;
    for (int i = 0; i < 24; i++) begin
      if (pw <= mag) begin
        pw = pw * 72'd10;
        n  = n + 1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/itpd_div10.sv
// Iterative divide-by-ten unit: one byte of the dividend per cycle.
`default_nettype none

module itpd_div10 #(
  parameter int MAG_W = 33
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire itpd_pkg::div_cmd_t   cmd,
  input  wire logic [MAG_W-1:0]     operand,
  output      itpd_pkg::div_status_t st
);

  localparam int CHUNKS = (MAG_W + 7) / 8;
  localparam int PW     = CHUNKS * 8;
  localparam int CW     = $clog2(CHUNKS);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [PW-1:0] mag;
  logic [3:0]    rem;

  logic [11:0]   dividend;
  logic [24:0]   prod;
  logic [7:0]    quo;
  logic [11:0]   back;
  logic [3:0]    rem_next;

  // Divide the running remainder and the top byte by ten
  always_comb begin
    dividend = {rem, mag[PW-1 -: 8]};
    prod     = 25'(dividend) * 25'(itpd_pkg::RECIP_TEN);
    quo      = prod[23:16];
    back     = 12'(quo) * 12'd10;
    rem_next = 4'(dividend - back);
  end

  // Sequence the byte steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(CHUNKS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Rotate quotient bytes in as dividend bytes shift out
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= 4'd0;
      if (cmd.load) begin
        mag <= PW'(operand);
      end
    end else if (busy) begin
      mag <= {mag[PW-9:0], quo};
      rem <= rem_next;
    end
  end

  assign st.done  = done;
  assign st.zero  = (mag == '0);
  assign st.digit = rem;

endmodule

`default_nettype wire

// File: rtl/int_to_padded_decimal_ascii_top.sv
// Top level of the signed integer to right-justified decimal text converter.
//
// Input channel (in_valid/in_ready, value) takes one signed integer per
// transaction; in_ready is high only while the converter is idle. The
// output channel (out_valid/out_ready) gives one character per transaction,
// most significant first: leading spaces, '-' for a negative value, then
// the digits, with last on the final character. A value that does not fit
// the configured buffer gives one result with out_char zero, a nonzero
// status and last set.
// Digits come from a shared divide-by-ten unit that takes one byte of the
// magnitude per cycle. Characters then leave at one per cycle while the
// receiver takes them.
// Reset returns the sequencer to idle and the registers to buffer_size 15,
// pad_width 8. A stalled receiver holds the output register; the sequencer
// waits for it and loses nothing. The APB port is to be written only while
// idle; the block itself does not enforce it.
`default_nettype none

module int_to_padded_decimal_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic signed [VALUE_BITS-1:0] value,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [7:0]                   out_char,
  output      logic [1:0]                   status,
  output      logic                         last,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready
);

  localparam int MAG_W  = VALUE_BITS + 1;
  localparam int DIGITS = itpd_pkg::num_digits(VALUE_BITS);
  localparam int DCW    = $clog2(DIGITS + 1);
  localparam int IW     = $clog2(DIGITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT,
    S_ERR
  } state_t;

  state_t                state;
  logic [6:0]            buffer_size;
  logic [5:0]            pad_width;
  logic                  sign_flag;
  logic [DCW-1:0]        digit_count;
  logic [5:0]            emit_index;
  logic [5:0]            total;
  logic [5:0]            pads;
  logic [1:0]            err_code;
  logic [3:0]            digit_store [DIGITS];

  itpd_pkg::div_cmd_t    div_cmd;
  itpd_pkg::div_status_t div_st;

  logic [6:0]            size_clamp;
  logic                  in_sign;
  logic                  width_fail;
  logic [MAG_W-1:0]      in_mag;
  logic                  fit_fail;
  logic [5:0]            text_next;
  logic [5:0]            total_next;
  logic                  slot_free;
  logic [5:0]            digit_idx;
  logic [3:0]            rd_digit;
  logic [7:0]            emit_char;
  logic                  wr_digit;

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= 7'd15;
      pad_width   <= 6'd8;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        itpd_pkg::REG_BUFFER_SIZE: buffer_size <= pwdata[6:0];
        itpd_pkg::REG_PAD_WIDTH:   pad_width   <= pwdata[5:0];
        default:                   buffer_size <= buffer_size;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      itpd_pkg::REG_BUFFER_SIZE: prdata = {25'd0, buffer_size};
      itpd_pkg::REG_PAD_WIDTH:   prdata = {26'd0, pad_width};
      default:                   prdata = 32'd0;
    endcase
  end

  // Checks, magnitude, character select and divider commands
  always_comb begin
    size_clamp = (buffer_size > itpd_pkg::MAX_BUF) ? itpd_pkg::MAX_BUF : buffer_size;
    in_sign    = value[VALUE_BITS-1];
    width_fail = size_clamp <= ({1'b0, pad_width} + 7'd1 + {6'd0, in_sign});
    in_mag     = in_sign ? (MAG_W'(0) - {in_sign, value}) : {1'b0, value};
    fit_fail   = size_clamp == (7'(digit_count) + 7'd1 + {6'd0, sign_flag});
    text_next  = 6'(digit_count) + 6'd1 + {5'd0, sign_flag};
    total_next = (pad_width > text_next) ? pad_width : text_next;
    slot_free  = !out_valid || out_ready;
    digit_idx  = total - 6'd1 - emit_index;
    rd_digit   = digit_store[digit_idx[IW-1:0]];
    if (emit_index < pads) begin
      emit_char = itpd_pkg::CH_SPACE;
    end else if (sign_flag && (emit_index == pads)) begin
      emit_char = itpd_pkg::CH_MINUS;
    end else begin
      emit_char = itpd_pkg::CH_ZERO + {4'd0, rd_digit};
    end
    wr_digit      = (state == S_DIV) && div_st.done && !fit_fail;
    div_cmd.load  = (state == S_IDLE);
    div_cmd.start = ((state == S_IDLE) && in_valid && !width_fail) ||
                    (wr_digit && !div_st.zero);
  end

  assign in_ready = (state == S_IDLE);

  // Shared divide-by-ten unit
  itpd_div10 #(
    .MAG_W (MAG_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .cmd     (div_cmd),
    .operand (in_mag),
    .st      (div_st)
  );

  // Store each digit, least significant first
  always_ff @(posedge clk) begin
    if (wr_digit) begin
      digit_store[digit_count[IW-1:0]] <= div_st.digit;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sign_flag   <= 1'b0;
      digit_count <= '0;
      emit_index  <= 6'd0;
      total       <= 6'd0;
      pads        <= 6'd0;
      err_code    <= itpd_pkg::ST_OK;
      out_valid   <= 1'b0;
      out_char    <= 8'd0;
      status      <= itpd_pkg::ST_OK;
      last        <= 1'b0;
    end else begin
      // Drop a taken result unless a new one loads below
      if (out_ready && (state != S_EMIT) && (state != S_ERR)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sign_flag   <= in_sign;
            digit_count <= '0;
            if (width_fail) begin
              err_code <= itpd_pkg::ST_WIDTH;
              state    <= S_ERR;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            if (fit_fail) begin
              err_code <= itpd_pkg::ST_FIT;
              state    <= S_ERR;
            end else begin
              digit_count <= digit_count + DCW'(1);
              if (div_st.zero) begin
                total      <= total_next;
                pads       <= total_next - text_next;
                emit_index <= 6'd0;
                state      <= S_EMIT;
              end
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_char   <= emit_char;
            status     <= itpd_pkg::ST_OK;
            last       <= (emit_index == total - 6'd1);
            emit_index <= emit_index + 6'd1;
            if (emit_index == total - 6'd1) begin
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_char  <= 8'd0;
            status    <= err_code;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/itpd_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
`default_nettype none

`include "int_to_padded_decimal_ascii_top_assert.svh"

module itpd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic [1:0] status,
  input wire logic       last
);

  logic err_result;
  logic ok_result;
  logic good_char;
  logic stalled;

  // Classify the result on the output port
  assign err_result = out_valid && (status != itpd_pkg::ST_OK);
  assign ok_result  = out_valid && (status == itpd_pkg::ST_OK);
  assign good_char  = (out_char == itpd_pkg::CH_SPACE) || (out_char == itpd_pkg::CH_MINUS) ||
                      ((out_char >= itpd_pkg::CH_ZERO) &&
                       (out_char <= itpd_pkg::CH_ZERO + 8'd9));
  assign stalled    = out_valid && !out_ready;

  // Busy right after taking a value
  `ITPD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // An error result stands alone with a zero character
  `ITPD_ASSERT_IMP(a_error_alone, err_result, last && (out_char == 8'd0))

  // Good results carry only space, minus or a digit
  `ITPD_ASSERT_IMP(a_legal_char, ok_result, good_char)

  // Hold a stalled result
  `ITPD_ASSERT_NXT(a_stall_hold, stalled, out_valid && $stable({out_char, status, last}))

endmodule

bind int_to_padded_decimal_ascii_top itpd_checker u_itpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_char  (out_char),
  .status    (status),
  .last      (last)
);

`default_nettype wire

// File: verif/tb_int_to_padded_decimal_ascii_top.sv
// Testbench for the signed integer to right-justified decimal text converter.
module tb_int_to_padded_decimal_ascii_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 20;
  localparam int HOLD_AT = 74;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 150;
  localparam int MAX_REPORTS = 60;

  // One character transaction on the output channel
  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] st;
    logic       last;
  } char_result_t;

  // Directed table rows: a register setting, a value checked by the predictor,
  // or a value with its text or error code written out
  typedef enum logic [1:0] {ROW_CFG, ROW_CHECK, ROW_TEXT, ROW_ERROR} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [6:0]        buf_size;
    logic [5:0]        pad_width;
    logic signed [31:0] v;
    string             text;
    logic [1:0]        st;
  } dir_row_t;

  localparam int N_DIR = 33;

  dir_row_t dir_rows [N_DIR] = '{
    // reset setting: buffer 15, width 8
    '{ROW_TEXT,  7'd0,   6'd0,  32'sd0,           "       0",    itpd_pkg::ST_OK},
    '{ROW_TEXT,  7'd0,   6'd0,  32'sh7FFF_FFFF,   "2147483647",  itpd_pkg::ST_OK},
    '{ROW_TEXT,  7'd0,   6'd0,  32'sh8000_0000,   "-2147483648", itpd_pkg::ST_OK},
    '{ROW_TEXT,  7'd0,   6'd0,  -32'sd1,          "      -1",    itpd_pkg::ST_OK},
    '{ROW_CHECK, 7'd0,   6'd0,  32'sd42,          "",            itpd_pkg::ST_OK},
    // widest field that still fits
    '{ROW_CFG,   7'd64,  6'd62, 32'sd0,           "",            itpd_pkg::ST_OK},
    '{ROW_CHECK, 7'd0,   6'd0,  32'sd7,           "",            itpd_pkg::ST_OK},
    '{ROW_ERROR, 7'd0,   6'd0,  -32'sd7,          "",            itpd_pkg::ST_WIDTH},
    '{ROW_CHECK, 7'd0,   6'd0,  32'sd1999999999,  "",            itpd_pkg::ST_OK},
    // oversized buffer, no padding
    '{ROW_CFG,   7'd127, 6'd0,  32'sd0,           "",            itpd_pkg::ST_OK},
    '{ROW_TEXT,  7'd0,   6'd0,  32'sd123,         "123",         itpd_pkg::ST_OK},
    '{ROW_CHECK, 7'd0,   6'd0,  -32'sd1000000000, "",            itpd_pkg::ST_OK},
    // tiny buffers always fail the width check
    '{ROW_CFG,   7'd0,   6'd0,  32'sd0,           "",            itpd_pkg::ST_OK},
    '{ROW_ERROR, 7'd0,   6'd0,  32'sd5,           "",            itpd_pkg::ST_WIDTH},
    '{ROW_CFG,   7'd1,   6'd0,  32'sd0,           "",            itpd_pkg::ST_OK},
    '{ROW_ERROR, 7'd0,   6'd0,  32'sd0,           "",            itpd_pkg::ST_WIDTH},
    // smallest legal buffer: one digit only
    '{ROW_CFG,   7'd2,   6'd0,  32'sd0,           "",            itpd_pkg::ST_OK},
    '{ROW_TEXT,  7'd0,   6'd0,  32'sd9,           "9",           itpd_pkg::ST_OK},
    '{ROW_ERROR, 7'd0,   6'd0,  32'sd10,          "",            itpd_pkg::ST_FIT},
    '{ROW_ERROR, 7'd0,   6'd0,  -32'sd1,          "",            itpd_pkg::ST_WIDTH},
    // ten digits fit, ten digits plus sign do not
    '{ROW_CFG,   7'd11,  6'd0,  32'sd0,           "",            itpd_pkg::ST_OK},
    '{ROW_TEXT,  7'd0,   6'd0,  32'sh7FFF_FFFF,   "2147483647",  itpd_pkg::ST_OK},
    '{ROW_ERROR, 7'd0,   6'd0,  32'sh8000_0000,   "",            itpd_pkg::ST_FIT},
    '{ROW_CHECK, 7'd0,   6'd0,  -32'sd999999999,  "",            itpd_pkg::ST_OK},
    // largest width field, capped buffer
    '{ROW_CFG,   7'd65,  6'd63, 32'sd0,           "",            itpd_pkg::ST_OK},
    '{ROW_ERROR, 7'd0,   6'd0,  32'sd0,           "",            itpd_pkg::ST_WIDTH},
    '{ROW_CFG,   7'd12,  6'd2,  32'sd0,           "",            itpd_pkg::ST_OK},
    '{ROW_CHECK, 7'd0,   6'd0,  -32'sd99,         "",            itpd_pkg::ST_OK},
    '{ROW_CHECK, 7'd0,   6'd0,  32'sd1000000000,  "",            itpd_pkg::ST_OK},
    '{ROW_CHECK, 7'd0,   6'd0,  32'sd5,           "",            itpd_pkg::ST_OK},
    '{ROW_CFG,   7'd3,   6'd1,  32'sd0,           "",            itpd_pkg::ST_OK},
    '{ROW_CHECK, 7'd0,   6'd0,  32'sd9,           "",            itpd_pkg::ST_OK},
    '{ROW_CHECK, 7'd0,   6'd0,  32'sd10,          "",            itpd_pkg::ST_OK}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_char;
  logic [1:0] status;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Register copies seen by the predictor
  logic [6:0] cfg_buf_size = 7'd15;
  logic [5:0] cfg_pad_width = 6'd8;

  char_result_t pending_chars [$];
  int n_errors = 0;
  int n_results = 0;
  int items_accepted = 0;
  int cycle_count = 0;
  logic rx_hold = 1'b0;
  int rx_wait = 0;

  int_to_padded_decimal_ascii_top #(.VALUE_BITS(32)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .status    (status),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Generate clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d characters outstanding",
               $time, cycle_count, pending_chars.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_error(input logic [1:0] code);
    pending_chars.push_back('{8'h00, code, 1'b1});
  endtask

  // Predict the characters of one value under the current register settings
  task automatic queue_decimal_text(input logic signed [31:0] v);
    int unsigned cap, sgn, ndig, text_len, total, pads, pos;
    logic [32:0] mag;
    logic [3:0] digits [0:9];
    logic [7:0] ch;
    cap = (cfg_buf_size > itpd_pkg::MAX_BUF) ? itpd_pkg::MAX_BUF : cfg_buf_size;
    sgn = v[31];
    // width check comes before any digit work
    if (cap <= cfg_pad_width + 1 + sgn) begin
      queue_error(itpd_pkg::ST_WIDTH);
      return;
    end
    // 33-bit magnitude keeps the most negative value exact
    mag = sgn ? 33'd0 - {1'b1, v} : {1'b0, v};
    ndig = 0;
    do begin
      if (cap == ndig + 1 + sgn) begin
        queue_error(itpd_pkg::ST_FIT);
        return;
      end
      digits[ndig] = 4'(mag % 10);
      ndig++;
      mag = mag / 10;
    end while (mag != 0);
    text_len = ndig + sgn;
    total = (cfg_pad_width > text_len) ? cfg_pad_width : text_len;
    pads = total - text_len;
    for (int unsigned k = 0; k < total; k++) begin
      if (k < pads) begin
        ch = itpd_pkg::CH_SPACE;
      end else if (sgn != 0 && k == pads) begin
        ch = itpd_pkg::CH_MINUS;
      end else begin
        pos = k - pads - sgn;
        ch = itpd_pkg::CH_ZERO + digits[ndig - 1 - pos];
      end
      pending_chars.push_back('{ch, itpd_pkg::ST_OK, (k + 1 == total)});
    end
  endtask

  // Values weighted toward digit-count boundaries and extremes
  function automatic logic signed [31:0] draw_value();
    int p;
    int k;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 2000) - 1000;
      2: begin
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        p = p - $urandom_range(0, 1);
        return $urandom_range(0, 1) ? -p : p;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh8000_0001;
          2: return 32'sh7FFF_FFFF;
          3: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
    endcase
  endfunction

  // Offer one value, after a random gap unless calm, and hold it until accepted
  task automatic send_value(input logic signed [31:0] v, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (!in_ready);
    items_accepted++;
  endtask

  // Stop offering and wait until every predicted character has arrived
  task automatic drain_output();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_register(input logic idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [6:0] bs, input logic [5:0] pw);
    drain_output();
    write_register(itpd_pkg::REG_BUFFER_SIZE, {25'd0, bs});
    write_register(itpd_pkg::REG_PAD_WIDTH, {26'd0, pw});
    cfg_buf_size = bs;
    cfg_pad_width = pw;
  endtask

  // Main stimulus: reset, directed table, random phases, final drain
  initial begin
    int mode;
    logic [6:0] bs;
    logic [5:0] pw;
    bit calm;
    logic signed [31:0] v;
    string txt;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    for (int r = 0; r < N_DIR; r++) begin
      case (dir_rows[r].kind)
        ROW_CFG: apply_settings(dir_rows[r].buf_size, dir_rows[r].pad_width);
        ROW_CHECK: begin
          send_value(dir_rows[r].v, 1'b0);
          queue_decimal_text(dir_rows[r].v);
        end
        ROW_TEXT: begin
          send_value(dir_rows[r].v, 1'b0);
          txt = dir_rows[r].text;
          for (int i = 0; i < txt.len(); i++)
            pending_chars.push_back('{txt[i], itpd_pkg::ST_OK, (i == txt.len() - 1)});
        end
        default: begin
          send_value(dir_rows[r].v, 1'b0);
          queue_error(dir_rows[r].st);
        end
      endcase
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      mode = $urandom_range(0, 4);
      case (mode)
        0: begin
          bs = 7'($urandom_range(0, 127));
          pw = 6'($urandom_range(0, 63));
        end
        1: begin
          pw = 6'($urandom_range(30, 62));
          bs = 7'($urandom_range(pw + 2, 127));
        end
        default: begin
          pw = 6'($urandom_range(0, 12));
          bs = 7'(pw + $urandom_range(2, 14));
        end
      endcase
      apply_settings(bs, pw);
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        v = draw_value();
        send_value(v, calm);
        queue_decimal_text(v);
        // occasionally let the output run dry before the next value
        if ($urandom_range(0, 24) == 0)
          drain_output();
      end
    end

    drain_output();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    wait (items_accepted >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Pace out_ready: random stall per character, calm stretches between
  always @(posedge clk) begin : pace_receiver
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (rx_hold) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      w = ((n_results / 64) % 4 == 3) ? 0 : $urandom_range(0, 5);
      out_ready <= (w == 0);
      rx_wait <= w;
    end else if (!out_ready) begin
      if (rx_wait <= 1)
        out_ready <= 1'b1;
      if (rx_wait > 0)
        rx_wait <= rx_wait - 1;
    end
  end

  task automatic report_mismatch(input string field, input int want, input int got);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t: %s mismatch on character %0d, expected %0h, actual %0h",
               $time, field, n_results, want, got);
  endtask

  // Compare each output transaction with the oldest predicted character
  always @(posedge clk) begin : check_output
    char_result_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_chars.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: unexpected character, expected none, actual %0h/%0h/%0b",
                   $time, out_char, status, last);
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch)
          report_mismatch("out_char", want.ch, out_char);
        if (status !== want.st)
          report_mismatch("status", want.st, status);
        if (last !== want.last)
          report_mismatch("last", want.last, last);
      end
    end
  end

endmodule
